/* design/sprite_sheet_animator_top_macros.svh */
// Assertion macros shared by the sprite sheet animator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SPRITE_SHEET_ANIMATOR_TOP_MACROS_SVH
`define SPRITE_SHEET_ANIMATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSA_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSA_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

/* design/ssa_pkg.sv */
// Types and constants of the sprite sheet animator.
// Used by the configuration bank and the top level.
`timescale 1ns / 1ps

package ssa_pkg;

	localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
	localparam logic [2:0] REG_NUM_FRAMES   = 3'd1;
	localparam logic [2:0] REG_LOOP_ENABLE  = 3'd2;
	localparam logic [2:0] REG_FIRST_CELL   = 3'd3;
	localparam logic [2:0] REG_TILE_WIDTH   = 3'd4;
	localparam logic [2:0] REG_TILE_HEIGHT  = 3'd5;
	localparam logic [2:0] REG_ZOOM         = 3'd6;

	localparam logic [1:0] CMD_TICK      = 2'd0;
	localparam logic [1:0] CMD_SET_FRAME = 2'd1;

	localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] COORD_MIN = -24'sh800000;

	typedef struct packed {
		logic [31:0] frame_period;
		logic [7:0]  num_frames;
		logic        loop_enable;
		logic [7:0]  first_cell;
		logic [12:0] tile_width;
		logic [12:0] tile_height;
		logic [15:0] zoom;
	} ssa_cfg_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_TICK  = 7'b0000010,
		ST_COLS  = 7'b0000100,
		ST_ROWS  = 7'b0001000,
		ST_CELL  = 7'b0010000,
		ST_COORD = 7'b0100000,
		ST_OUT   = 7'b1000000
	} ssa_state_t;

endpackage

/* design/ssa_cfg.sv */
// Configuration register bank of the sprite sheet animator.
// Depends on ssa_pkg for the register indexes and the register struct.
`timescale 1ns / 1ps

module ssa_cfg import ssa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output ssa_cfg_t    cfg
);

	ssa_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period <= '0;
			cfg_q.num_frames   <= 8'd1;
			cfg_q.loop_enable  <= 1'b1;
			cfg_q.first_cell   <= '0;
			cfg_q.tile_width   <= 13'd1;
			cfg_q.tile_height  <= 13'd1;
			cfg_q.zoom         <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_data;
				REG_NUM_FRAMES:   cfg_q.num_frames   <= cfg_data[7:0];
				REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_data[0];
				REG_FIRST_CELL:   cfg_q.first_cell   <= cfg_data[7:0];
				REG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_data[12:0];
				REG_TILE_HEIGHT:  cfg_q.tile_height  <= cfg_data[12:0];
				REG_ZOOM:         cfg_q.zoom         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/ssa_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the sprite sheet animator top level.
`timescale 1ns / 1ps

module ssa_div #(
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [31:0]   rem
);

	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* design/sprite_sheet_animator_top.sv */
// Sprite sheet animator: frame sequencing and corner texture coordinates.
// Instantiates ssa_cfg and ssa_div; depends on ssa_pkg and the assertion macros.
//
// Input items arrive on in_valid / in_stall and results leave on
// out_valid / out_stall; a transfer happens when valid is high and stall is low.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Every item yields exactly one result. All divisions run one after another on
// a single restoring divider of DW = max(32, COORD_FRAC_BITS + 23) bits. An
// item runs seven divisions (eight for a tick with a nonzero frame period).
// in_stall is high while an item is being processed; a finished result sits
// in the output register, so the next item may be accepted while it waits.
// When the receiver stalls, the next result is held back until the output
// register has been emptied. Reset clears the frame, the elapsed time and the
// configuration to their documented defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "sprite_sheet_animator_top_macros.svh"

module sprite_sheet_animator_top import ssa_pkg::*; #(
	parameter int TICK_STEP       = 1,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         frame_index,
	input  logic [12:0]        image_width,
	input  logic [12:0]        image_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         anim_frame,
	output logic signed [23:0] top_left_u,
	output logic signed [23:0] top_left_v,
	output logic signed [23:0] top_right_u,
	output logic signed [23:0] top_right_v,
	output logic signed [23:0] bottom_left_u,
	output logic signed [23:0] bottom_left_v,
	output logic signed [23:0] bottom_right_u,
	output logic signed [23:0] bottom_right_v
);

	localparam int DW = (COORD_FRAC_BITS + 23 > 32) ? COORD_FRAC_BITS + 23 : 32;

	ssa_cfg_t   cfg;
	ssa_state_t state_q;
	logic       issued_q;
	logic [1:0] corner_q;

	logic [31:0] elapsed_q;
	logic [7:0]  frame_q;
	logic [12:0] imgw_q;
	logic [12:0] imgh_q;
	logic [12:0] cols_q;
	logic [12:0] rows_q;
	logic [12:0] col_q;
	logic [8:0]  row_q;
	logic signed [23:0] lu_q, ru_q, tv_q, bv_q;

	logic        out_valid_q;
	logic [7:0]  frame_out_q;
	logic signed [23:0] tlu_q, tlv_q, tru_q, trv_q, blu_q, blv_q, bru_q, brv_q;

	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [31:0]   div_divisor;
	logic          div_busy;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [31:0]   div_rem;

	logic [12:0] fw_eff, fh_eff;
	logic [7:0]  cnt_eff;
	logic [8:0]  cell_idx;
	logic signed [17:0] zsh;
	logic signed [22:0] num;
	logic [21:0]   den2;
	logic signed [DW:0] numer_big;
	logic          neg;
	logic [DW:0]   mag;
	logic [DW:0]   qmag;
	logic signed [23:0] coord_sat;
	logic [12:0]   quo13;

	ssa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssa_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign fw_eff   = (cfg.tile_width == '0) ? 13'd1 : cfg.tile_width;
	assign fh_eff   = (cfg.tile_height == '0) ? 13'd1 : cfg.tile_height;
	assign cnt_eff  = (cfg.num_frames == '0) ? 8'd1 : cfg.num_frames;
	assign cell_idx = {1'b0, cfg.first_cell} + {1'b0, frame_q};
	assign zsh      = $signed({2'b00, cfg.zoom}) - 18'sd256;
	assign quo13    = div_quo[12:0];

	// Numerator of one coordinate, selected by the corner counter.
	always_comb begin
		case (corner_q)
			2'd0: begin
				num  = $signed({10'd0, col_q}) * 23'sd256 + 23'(zsh);
				den2 = {cols_q, 9'd0};
			end
			2'd1: begin
				num  = ($signed({10'd0, col_q}) + 23'sd1) * 23'sd256 - 23'(zsh);
				den2 = {cols_q, 9'd0};
			end
			2'd2: begin
				num  = $signed({14'd0, row_q}) * 23'sd256 + 23'(zsh);
				den2 = {rows_q, 9'd0};
			end
			default: begin
				num  = ($signed({14'd0, row_q}) + 23'sd1) * 23'sd256 - 23'(zsh);
				den2 = {rows_q, 9'd0};
			end
		endcase
		numer_big = ($signed({{(DW + 1 - 23){num[22]}}, num}) <<< (COORD_FRAC_BITS + 1))
			+ $signed({{(DW + 1 - 21){1'b0}}, den2[21:1]});
		neg = numer_big[DW];
		mag = neg ? (-numer_big) : numer_big;
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = 32'd1;
		case (state_q)
			ST_TICK: begin
				div_dividend = DW'(elapsed_q);
				div_divisor  = cfg.frame_period;
			end
			ST_COLS: begin
				div_dividend = DW'(imgw_q);
				div_divisor  = 32'(fw_eff);
			end
			ST_ROWS: begin
				div_dividend = DW'(imgh_q);
				div_divisor  = 32'(fh_eff);
			end
			ST_CELL: begin
				div_dividend = DW'(cell_idx);
				div_divisor  = 32'(cols_q);
			end
			ST_COORD: begin
				div_dividend = mag[DW-1:0];
				div_divisor  = 32'(den2);
			end
			default: ;
		endcase
		if (state_q != ST_IDLE && state_q != ST_OUT && !issued_q && !div_busy) begin
			div_start = 1'b1;
		end
	end

	// Floor rounding for negative numerators, then saturation to 24 bits.
	always_comb begin
		qmag = {1'b0, div_quo} + (DW + 1)'(div_rem != '0);
		if (!neg) begin
			coord_sat = ({1'b0, div_quo} > (DW + 1)'(COORD_MAX)) ? COORD_MAX : div_quo[23:0];
		end else if (qmag > (DW + 1)'(24'h800000)) begin
			coord_sat = COORD_MIN;
		end else begin
			coord_sat = -qmag[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			corner_q    <= '0;
			elapsed_q   <= '0;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_start) begin
				issued_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_TICK) begin
							elapsed_q <= elapsed_q + 32'(TICK_STEP);
						end else if (cmd == CMD_SET_FRAME) begin
							frame_q <= frame_index;
						end
						state_q <= (cmd == CMD_TICK && cfg.frame_period != '0) ? ST_TICK
							: ST_COLS;
					end
				end
				ST_TICK: begin
					if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_COLS;
						if (div_quo[31:0] >= 32'(cnt_eff)) begin
							if (cfg.loop_enable) begin
								elapsed_q <= '0;
								frame_q   <= '0;
							end else begin
								frame_q <= cnt_eff - 8'd1;
							end
						end else begin
							frame_q <= div_quo[7:0];
						end
					end
				end
				ST_COLS: begin
					if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_ROWS;
					end
				end
				ST_ROWS: begin
					if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_CELL;
					end
				end
				ST_CELL: begin
					if (div_done) begin
						issued_q <= 1'b0;
						corner_q <= '0;
						state_q  <= ST_COORD;
					end
				end
				ST_COORD: begin
					if (div_done) begin
						issued_q <= 1'b0;
						corner_q <= corner_q + 2'd1;
						if (corner_q == 2'd3) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			imgw_q <= image_width;
			imgh_q <= image_height;
		end
		if (div_done) begin
			case (state_q)
				ST_COLS: cols_q <= (quo13 == '0) ? 13'd1 : quo13;
				ST_ROWS: rows_q <= (quo13 == '0) ? 13'd1 : quo13;
				ST_CELL: begin
					col_q <= div_rem[12:0];
					row_q <= div_quo[8:0];
				end
				ST_COORD: begin
					case (corner_q)
						2'd0:    lu_q <= coord_sat;
						2'd1:    ru_q <= coord_sat;
						2'd2:    tv_q <= coord_sat;
						default: bv_q <= coord_sat;
					endcase
				end
				default: ;
			endcase
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			frame_out_q <= frame_q;
			tlu_q <= lu_q;
			tlv_q <= tv_q;
			tru_q <= ru_q;
			trv_q <= tv_q;
			blu_q <= lu_q;
			blv_q <= bv_q;
			bru_q <= ru_q;
			brv_q <= bv_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign anim_frame     = frame_out_q;
	assign top_left_u     = tlu_q;
	assign top_left_v     = tlv_q;
	assign top_right_u    = tru_q;
	assign top_right_v    = trv_q;
	assign bottom_left_u  = blu_q;
	assign bottom_left_v  = blv_q;
	assign bottom_right_u = bru_q;
	assign bottom_right_v = brv_q;

	`SSA_ASSERT_IMP(a_idle_div_quiet, clk, arst_n, state_q == ST_IDLE, !div_busy && !div_done, "divider active while idle")
	`SSA_ASSERT_IMP(a_start_when_free, clk, arst_n, div_start, !div_busy && !issued_q, "divider started twice")
	`SSA_ASSERT_NXT(a_start_busy, clk, arst_n, div_start, div_busy, "divider did not start")

endmodule

/* tb/sv/ssa_checker.sv */
// Checker for the sprite sheet animator: watches configuration writes and both channels.
// It predicts every result from its own copy of the state and compares field by field.
// Depends on ssa_pkg.
`timescale 1ns / 1ps

module ssa_checker import ssa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         frame_index,
	input  logic [12:0]        image_width,
	input  logic [12:0]        image_height,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         anim_frame,
	input  logic signed [23:0] top_left_u,
	input  logic signed [23:0] top_left_v,
	input  logic signed [23:0] top_right_u,
	input  logic signed [23:0] top_right_v,
	input  logic signed [23:0] bottom_left_u,
	input  logic signed [23:0] bottom_left_v,
	input  logic signed [23:0] bottom_right_u,
	input  logic signed [23:0] bottom_right_v,
	output int                 failures,
	output int                 pending
);

	localparam int TICK_STEP = 1;
	localparam int FRAC_BITS = 16;

	typedef logic [8:0][23:0] uv_set_t;

	ssa_cfg_t    cfg;
	logic [31:0] elapsed;
	logic [7:0]  frame_now;
	uv_set_t     uv_queue[$];

	assign pending = uv_queue.size();

	function automatic logic [23:0] scale_uv(longint numer, longint den);
		longint num2, den2, q;
		num2 = 2 * (numer <<< FRAC_BITS) + den;
		den2 = 2 * den;
		q = num2 / den2;
		if ((num2 % den2) != 0 && num2 < 0)
			q = q - 1;
		if (q > 8388607)
			q = 8388607;
		if (q < -8388608)
			q = -8388608;
		return q[23:0];
	endfunction

	function automatic uv_set_t corners(logic [7:0] frame, logic [12:0] img_w,
			logic [12:0] img_h);
		longint fw, fh, cols, rows, cidx, col, row, z, lnum, rnum, tnum, bnum;
		uv_set_t r;
		fw = (cfg.tile_width == 0) ? 1 : cfg.tile_width;
		fh = (cfg.tile_height == 0) ? 1 : cfg.tile_height;
		cols = img_w / fw;
		rows = img_h / fh;
		if (cols == 0)
			cols = 1;
		if (rows == 0)
			rows = 1;
		cidx = cfg.first_cell + frame;
		col = cidx % cols;
		row = cidx / cols;
		z = longint'(cfg.zoom) - 256;
		lnum = col * 256 + z;
		rnum = (col + 1) * 256 - z;
		tnum = row * 256 + z;
		bnum = (row + 1) * 256 - z;
		r[0] = {16'd0, frame};
		r[1] = scale_uv(lnum, cols * 256);
		r[2] = scale_uv(tnum, rows * 256);
		r[3] = scale_uv(rnum, cols * 256);
		r[4] = r[2];
		r[5] = r[1];
		r[6] = scale_uv(bnum, rows * 256);
		r[7] = r[3];
		r[8] = r[6];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] t;
		logic [31:0] f;
		logic [31:0] cnt;
		logic [7:0]  nf;
		uv_set_t     got;
		uv_set_t     want;
		if (!arst_n) begin
			cfg.frame_period <= 32'd0;
			cfg.num_frames   <= 8'd1;
			cfg.loop_enable  <= 1'b1;
			cfg.first_cell   <= 8'd0;
			cfg.tile_width   <= 13'd1;
			cfg.tile_height  <= 13'd1;
			cfg.zoom         <= 16'd256;
			elapsed   <= 32'd0;
			frame_now <= 8'd0;
			failures  <= 0;
			uv_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_PERIOD: cfg.frame_period <= cfg_data;
					REG_NUM_FRAMES:   cfg.num_frames   <= cfg_data[7:0];
					REG_LOOP_ENABLE:  cfg.loop_enable  <= cfg_data[0];
					REG_FIRST_CELL:   cfg.first_cell   <= cfg_data[7:0];
					REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[12:0];
					REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[12:0];
					REG_ZOOM:         cfg.zoom         <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				t = elapsed;
				nf = frame_now;
				if (cmd == CMD_TICK) begin
					t = t + TICK_STEP;
					if (cfg.frame_period != 0) begin
						cnt = (cfg.num_frames == 0) ? 32'd1 : 32'(cfg.num_frames);
						f = t / cfg.frame_period;
						if (f >= cnt) begin
							if (cfg.loop_enable) begin
								t = 32'd0;
								nf = 8'd0;
							end else begin
								nf = 8'(cnt - 1);
							end
						end else begin
							nf = f[7:0];
						end
					end
				end else if (cmd == CMD_SET_FRAME) begin
					nf = frame_index;
				end
				elapsed <= t;
				frame_now <= nf;
				uv_queue.push_back(corners(nf, image_width, image_height));
			end
			if (out_valid && !out_stall) begin
				got = {bottom_right_v, bottom_right_u, bottom_left_v, bottom_left_u,
					top_right_v, top_right_u, top_left_v, top_left_u,
					16'd0, anim_frame};
				if (uv_queue.size() == 0) begin
					failures <= failures + 1;
					if (failures < 10)
						$display("unexpected result transfer at %0t", $realtime);
				end else begin
					want = uv_queue.pop_front();
					if (got != want) begin
						failures <= failures + 1;
						if (failures < 10)
							for (int i = 0; i < 9; i++)
								if (got[i] != want[i])
									$display("field %0d: expected %h, got %h", i, want[i],
										got[i]);
					end
				end
			end
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the sprite sheet animator: clock, reset, stimulus and verdict.
// Depends on ssa_pkg, sprite_sheet_animator_top and ssa_checker.
`timescale 1ns / 1ps

module tb import ssa_pkg::*;;

	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int         DOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [7:0]         frame_index;
	logic [12:0]        image_width;
	logic [12:0]        image_height;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         anim_frame;
	logic signed [23:0] top_left_u, top_left_v, top_right_u, top_right_v;
	logic signed [23:0] bottom_left_u, bottom_left_v, bottom_right_u, bottom_right_v;
	int                 failures;
	int                 pending;
	int                 quiet;
	bit                 steady;
	bit                 hold_req;
	logic [12:0]        cell_w;
	logic [12:0]        cell_h;

	sprite_sheet_animator_top u_top (.*);

	ssa_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send(logic [1:0] c, logic [7:0] idx, logic [12:0] w, logic [12:0] h);
		int gap;
		in_valid = 1'b1;
		cmd = c;
		frame_index = idx;
		image_width = w;
		image_height = h;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic setup(logic [31:0] per, logic [7:0] cnt, logic lp, logic [7:0] st,
			logic [12:0] fw, logic [12:0] fh, logic [15:0] zm);
		write_reg(REG_FRAME_PERIOD, per);
		write_reg(REG_NUM_FRAMES, cnt);
		write_reg(REG_LOOP_ENABLE, {31'd0, lp});
		write_reg(REG_FIRST_CELL, st);
		write_reg(REG_TILE_WIDTH, fw);
		write_reg(REG_TILE_HEIGHT, fh);
		write_reg(REG_ZOOM, zm);
		cell_w = fw;
		cell_h = fh;
	endtask

	function automatic logic [12:0] sheet_size(logic [12:0] unit);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 13'((unit == 0 ? 1 : unit) * $urandom_range(1, 16));
		if (r < 80)
			return 13'($urandom_range(1, 4));
		return 13'($urandom_range(0, 8191));
	endfunction

	task automatic r_stall();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70) begin
			out_stall = 1'b0;
		end else if (r < 95) begin
			out_stall = 1'b1;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end else begin
			out_stall = 1'b1;
			repeat ($urandom_range(20, 300)) @(negedge clk);
		end
	endtask

	initial begin
		int r;
		logic [1:0] c;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		frame_index = '0;
		image_width = 13'd1;
		image_height = 13'd1;
		steady = 1'b0;
		hold_req = 1'b0;
		cell_w = 13'd1;
		cell_h = 13'd1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(CMD_QUERY, 8'd0, 13'd1, 13'd1);
		send(CMD_TICK, 8'd0, 13'd4096, 13'd4096);
		send(CMD_SPARE, 8'd77, 13'd8191, 13'd8191);
		send(CMD_SET_FRAME, 8'd255, 13'd4096, 13'd1);
		drain();
		setup(32'd1, 8'd0, 1'b1, 8'd255, 13'd0, 13'd0, 16'd0);
		send(CMD_TICK, 8'd0, 13'd16, 13'd16);
		send(CMD_TICK, 8'd0, 13'd0, 13'd0);
		send(CMD_SET_FRAME, 8'd200, 13'd1, 13'd8191);
		drain();
		setup(32'd2, 8'd3, 1'b0, 8'd0, 13'd4096, 13'd4096, 16'd65535);
		repeat (8) send(CMD_TICK, 8'd0, 13'd4096, 13'd4096);
		send(CMD_QUERY, 8'd0, 13'd1, 13'd1);
		drain();
		setup(32'hFFFFFFFF, 8'd255, 1'b1, 8'd5, 13'd8, 13'd8, 16'd512);
		repeat (3) send(CMD_TICK, 8'd0, 13'd32, 13'd8);
		send(CMD_SET_FRAME, 8'd254, 13'd32, 13'd8);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			r = $urandom_range(0, 9);
			setup(r < 2 ? 32'd0 : r < 8 ? 32'($urandom_range(1, 6)) : $urandom,
				$urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 1) * 255)
					: 8'($urandom_range(1, 20)),
				1'($urandom),
				$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 8)),
				$urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 64)),
				$urandom_range(0, 9) == 0 ? 13'($urandom) : 13'($urandom_range(1, 64)),
				$urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(200, 300)));
			steady = (ph % 4 == 1);
			if (ph == 3)
				hold_req = 1'b1;
			repeat (42) begin
				r = $urandom_range(0, 99);
				c = r < 60 ? CMD_TICK : r < 75 ? CMD_SET_FRAME : r < 90 ? CMD_QUERY
					: CMD_SPARE;
				send(c, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20)),
					sheet_size(cell_w), sheet_size(cell_h));
			end
			drain();
		end

		repeat (400) @(posedge clk);
		if (failures == 0)
			$display("PASS sprite_sheet_animator_top");
		else
			$display("FAIL sprite_sheet_animator_top");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (1500) @(negedge clk);
				hold_req = 1'b0;
			end
			r_stall();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= DOG_LIMIT) begin
			$display("FAIL sprite_sheet_animator_top");
			$finish;
		end
	end

endmodule
